FILE: rtl/core/cfsp_pkg.sv
// Shared definitions for the CRC16 framed stream parser.
// Holds framing constants, result codes, the parse result struct and the CRC byte update.
// No dependencies.
package cfsp_pkg;

    // Default payload capacity of a frame
    localparam int MAX_PAYLOAD_DEF = 32;

    // Framing constants
    localparam logic [7:0]  PRE_FIRST    = 8'hAA;
    localparam logic [7:0]  PRE_SECOND   = 8'h55;
    localparam int          LEN_OVERHEAD = 4;
    localparam int          HDR_BYTES    = 3;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // Byte positions inside a frame, counted from the first preamble byte
    localparam int POS_LEN     = 2;
    localparam int POS_CMD     = 3;
    localparam int POS_ADDR    = 4;
    localparam int POS_PAYLOAD = 5;

    // Width of the payload count field
    localparam int COUNT_W = 6;
    typedef logic [COUNT_W-1:0] t_count;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_NEED_MORE = 2'd0,
        STATUS_FRAME_OK  = 2'd1,
        STATUS_CRC_ERR   = 2'd2,
        STATUS_LEN_ERR   = 2'd3
    } t_status;

    // Outcome of one parsed byte
    typedef struct packed {
        t_status    status;
        logic [7:0] cmd;
        logic [7:0] addr;
        t_count     count;
    } t_parse_res;

    // CRC16/MODBUS update over one byte, reflected polynomial
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

FILE: rtl/core/cfsp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cfsp_parser.sv
// Frame parser: preamble hunt, header capture, CRC accumulation and payload store writes.
// Depends on cfsp_pkg.
module cfsp_parser #(
    parameter int MAX_PAYLOAD = cfsp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [7:0]                     i_byte,
    output cfsp_pkg::t_parse_res           o_res,
    output logic                           o_we,
    output logic [$clog2(MAX_PAYLOAD)-1:0] o_waddr,
    output logic [7:0]                     o_wdata
);

    localparam int AW      = $clog2(MAX_PAYLOAD);
    localparam int PW      = $clog2(MAX_PAYLOAD + cfsp_pkg::LEN_OVERHEAD + cfsp_pkg::HDR_BYTES + 1);
    localparam int LEN_MAX = cfsp_pkg::LEN_OVERHEAD + MAX_PAYLOAD;

    logic          r_saw_sync, n_saw_sync;
    logic [PW-1:0] r_pos,      n_pos;
    logic [PW-1:0] r_total,    n_total;
    logic [15:0]   r_crc,      n_crc;
    logic [7:0]    r_len,      n_len;
    logic [7:0]    r_cmd,      n_cmd;
    logic [7:0]    r_addr,     n_addr;
    logic [7:0]    r_crc_lo,   n_crc_lo;

    logic [15:0]   crc_next;
    logic          len_bad;

    // CRC step for the current byte; the length byte restarts from the seed
    always_comb begin
        if (r_pos == PW'(cfsp_pkg::POS_LEN)) begin
            crc_next = cfsp_pkg::crc_update(cfsp_pkg::CRC_INIT, i_byte);
        end else begin
            crc_next = cfsp_pkg::crc_update(r_crc, i_byte);
        end
    end

    assign len_bad = (i_byte < 8'(cfsp_pkg::LEN_OVERHEAD)) || (i_byte > 8'(LEN_MAX));

    // Decode the byte against the frame position
    always_comb begin
        n_saw_sync = r_saw_sync;
        n_pos      = r_pos;
        n_total    = r_total;
        n_crc      = r_crc;
        n_len      = r_len;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_crc_lo   = r_crc_lo;
        o_res      = '{status: cfsp_pkg::STATUS_NEED_MORE, cmd: '0, addr: '0, count: '0};
        o_we       = 1'b0;
        o_waddr    = AW'(r_pos - PW'(cfsp_pkg::POS_PAYLOAD));
        o_wdata    = i_byte;

        if (i_take) begin
            if (r_pos == '0) begin
                // Hunt for the preamble; repeated first bytes keep it armed
                if (!r_saw_sync) begin
                    if (i_byte == cfsp_pkg::PRE_FIRST) begin
                        n_saw_sync = 1'b1;
                    end
                end else if (i_byte == cfsp_pkg::PRE_SECOND) begin
                    n_pos   = PW'(cfsp_pkg::POS_LEN);
                    n_total = '0;
                    n_crc   = cfsp_pkg::CRC_INIT;
                end else if (i_byte != cfsp_pkg::PRE_FIRST) begin
                    n_saw_sync = 1'b0;
                end
            end else begin
                n_pos = r_pos + PW'(1);
                if (r_pos == PW'(cfsp_pkg::POS_LEN)) begin
                    // Length byte: check range, then start the CRC
                    n_len = i_byte;
                    if (len_bad) begin
                        n_saw_sync   = 1'b0;
                        n_pos        = '0;
                        n_total      = '0;
                        n_crc        = cfsp_pkg::CRC_INIT;
                        o_res.status = cfsp_pkg::STATUS_LEN_ERR;
                    end else begin
                        n_crc   = crc_next;
                        n_total = PW'(i_byte) + PW'(cfsp_pkg::HDR_BYTES);
                    end
                end else if (r_pos == PW'(cfsp_pkg::POS_CMD)) begin
                    n_cmd = i_byte;
                    n_crc = crc_next;
                end else if (r_pos == PW'(cfsp_pkg::POS_ADDR)) begin
                    n_addr = i_byte;
                    n_crc  = crc_next;
                end else if (r_pos == r_total - PW'(2)) begin
                    n_crc_lo = i_byte;
                end else if (r_pos == r_total - PW'(1)) begin
                    // Closing CRC byte: compare and return to the hunt
                    n_saw_sync = 1'b0;
                    n_pos      = '0;
                    n_total    = '0;
                    n_crc      = cfsp_pkg::CRC_INIT;
                    if ({i_byte, r_crc_lo} != r_crc) begin
                        o_res.status = cfsp_pkg::STATUS_CRC_ERR;
                    end else begin
                        o_res.status = cfsp_pkg::STATUS_FRAME_OK;
                        o_res.cmd    = r_cmd;
                        o_res.addr   = r_addr;
                        o_res.count  = cfsp_pkg::t_count'(r_len - 8'(cfsp_pkg::LEN_OVERHEAD));
                    end
                end else begin
                    // Payload byte: store it and fold it into the CRC
                    o_we  = 1'b1;
                    n_crc = crc_next;
                end
            end
        end
    end

    // Framing control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saw_sync <= 1'b0;
            r_pos      <= '0;
            r_total    <= '0;
            r_crc      <= cfsp_pkg::CRC_INIT;
        end else begin
            r_saw_sync <= n_saw_sync;
            r_pos      <= n_pos;
            r_total    <= n_total;
            r_crc      <= n_crc;
        end
    end

    // Captured header bytes
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_cmd    <= n_cmd;
        r_addr   <= n_addr;
        r_crc_lo <= n_crc_lo;
    end

endmodule

FILE: rtl/core/cfsp_readout.sv
// Result sequencer: output register, header result and payload burst read from the RAM.
// Depends on cfsp_pkg.
module cfsp_readout #(
    parameter int MAX_PAYLOAD = cfsp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  cfsp_pkg::t_parse_res           i_res,
    input  logic [7:0]                     i_rdata,
    output logic [$clog2(MAX_PAYLOAD)-1:0] o_raddr,
    output logic                           o_ready,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_status,
    output logic [7:0]                     o_cmd_code,
    output logic [7:0]                     o_dest_addr,
    output logic [5:0]                     o_payload_count,
    output logic                           o_is_payload,
    output logic [7:0]                     o_payload_byte,
    output logic                           o_last
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } t_state;

    t_state                r_state,    n_state;
    logic                  r_valid,    n_valid;
    logic [AW-1:0]         r_rd_idx,   n_rd_idx;
    logic [AW-1:0]         r_last_idx, n_last_idx;
    cfsp_pkg::t_status     r_status,   n_status;
    logic [7:0]            r_cmd,      n_cmd;
    logic [7:0]            r_addr,     n_addr;
    cfsp_pkg::t_count      r_count,    n_count;
    logic                  r_is_pay,   n_is_pay;
    logic [7:0]            r_pay,      n_pay;
    logic                  r_last,     n_last;

    logic                  slot_free;

    assign slot_free = !r_valid || !i_stall;

    // Load the output register from a new request or from the payload burst
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid && i_stall;
        n_rd_idx   = r_rd_idx;
        n_last_idx = r_last_idx;
        n_status   = r_status;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_count    = r_count;
        n_is_pay   = r_is_pay;
        n_pay      = r_pay;
        n_last     = r_last;

        case (r_state)
            ST_IDLE: begin
                n_rd_idx = '0;
                if (i_take) begin
                    n_valid  = 1'b1;
                    n_status = i_res.status;
                    n_cmd    = i_res.cmd;
                    n_addr   = i_res.addr;
                    n_count  = i_res.count;
                    n_is_pay = 1'b0;
                    n_pay    = '0;
                    n_last   = 1'b1;
                    if (i_res.status == cfsp_pkg::STATUS_FRAME_OK && i_res.count != '0) begin
                        n_last     = 1'b0;
                        n_last_idx = AW'(i_res.count - cfsp_pkg::t_count'(1));
                        n_state    = ST_BURST;
                    end
                end
            end
            ST_BURST: begin
                // Emit one payload byte per free slot; read data follows the index
                if (slot_free) begin
                    n_valid  = 1'b1;
                    n_is_pay = 1'b1;
                    n_pay    = i_rdata;
                    n_last   = (r_rd_idx == r_last_idx);
                    if (r_rd_idx == r_last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_valid = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Burst index and result payload
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_last_idx <= n_last_idx;
        r_status   <= n_status;
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_count    <= n_count;
        r_is_pay   <= n_is_pay;
        r_pay      <= n_pay;
        r_last     <= n_last;
    end

    assign o_raddr         = n_rd_idx;
    assign o_ready         = (r_state == ST_IDLE) && slot_free;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_cmd_code      = r_cmd;
    assign o_dest_addr     = r_addr;
    assign o_payload_count = r_count;
    assign o_is_payload    = r_is_pay;
    assign o_payload_byte  = r_pay;
    assign o_last          = r_last;

endmodule

FILE: rtl/core/crc16_frame_stream_parser_unit.sv
// CRC16 framed stream parser, top level.
// A request's first result is registered and valid in the cycle after the request is accepted.
// Throughput: one byte per cycle when the output is free; a good frame with N payload bytes
// holds the input off while the payload RAM is read out, one entry per cycle unless stalled.
// Reset: synchronous, active low; clears framing and output control, the payload RAM keeps data.
// Depends on cfsp_pkg, cfsp_parser, cfsp_ram and cfsp_readout.
module crc16_frame_stream_parser_unit #(
    parameter int MAX_PAYLOAD = cfsp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_cmd_code,
    output logic [7:0] o_dest_addr,
    output logic [5:0] o_payload_count,
    output logic       o_is_payload,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    logic                 ready;
    logic                 take;
    cfsp_pkg::t_parse_res res;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [7:0]           wdata;
    logic [AW-1:0]        raddr;
    logic [7:0]           rdata;

    // Accept a request only when the sequencer can take its result
    assign o_stall = !ready;
    assign take    = i_valid && ready;

    cfsp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx_byte),
        .o_res   (res),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata)
    );

    cfsp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cfsp_readout #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_readout (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_res           (res),
        .i_rdata         (rdata),
        .o_raddr         (raddr),
        .o_ready         (ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_cmd_code      (o_cmd_code),
        .o_dest_addr     (o_dest_addr),
        .o_payload_count (o_payload_count),
        .o_is_payload    (o_is_payload),
        .o_payload_byte  (o_payload_byte),
        .o_last          (o_last)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for crc16_frame_stream_parser_unit: byte stream in, parse results out.
// Predicts each result from its own CRC16/MODBUS frame decoder and checks them in order.
// Depends on cfsp_pkg and the parser RTL.
module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int CALM_TAIL      = 40;
    localparam int STIM_TARGET    = 170;

    typedef struct {
        logic [7:0] data;
        bit         drain;
        bit         hold;
    } t_rx_req;

    typedef struct packed {
        cfsp_pkg::t_status status;
        logic [7:0]        cmd;
        logic [7:0]        addr;
        logic [5:0]        count;
        logic              is_pay;
        logic [7:0]        pbyte;
        logic              last;
    } t_frame_result;

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_stall   = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_cmd_code;
    logic [7:0] o_dest_addr;
    logic [5:0] o_payload_count;
    logic       o_is_payload;
    logic [7:0] o_payload_byte;
    logic       o_last;

    t_rx_req       rx_pending[$];
    t_frame_result want_results[$];
    int            errors       = 0;
    int            idle_cycles  = 0;
    int            bytes_queued = 0;
    int            bytes_taken  = 0;
    bit            in_acc       = 0;
    bit            calm         = 0;
    int            hold_asks    = 0;
    int            hold_seen    = 0;
    int            gap_left     = 0;
    int            stall_left   = 0;
    int            hold_left    = 0;
    bit            pend_drain   = 0;
    bit            pend_hold    = 0;

    // Decoder state
    bit          hunt_armed      = 1'b0;
    logic [5:0]  frame_pos       = '0;
    logic [5:0]  frame_len_total = '0;
    logic [15:0] crc_acc         = cfsp_pkg::CRC_INIT;
    logic [7:0]  len_q           = '0;
    logic [7:0]  cmd_q           = '0;
    logic [7:0]  addr_q          = '0;
    logic [7:0]  crc_lo_q        = '0;
    logic [7:0]  pay_mem [cfsp_pkg::MAX_PAYLOAD_DEF];

    crc16_frame_stream_parser_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_cmd_code     (o_cmd_code),
        .o_dest_addr    (o_dest_addr),
        .o_payload_count(o_payload_count),
        .o_is_payload   (o_is_payload),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic note_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // CRC16/MODBUS over one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        repeat (8) r = r[0] ? ((r >> 1) ^ cfsp_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void hunt_reset();
        hunt_armed      = 1'b0;
        frame_pos       = '0;
        frame_len_total = '0;
        crc_acc         = cfsp_pkg::CRC_INIT;
    endfunction

    function automatic void push_single(input cfsp_pkg::t_status st);
        t_frame_result r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        want_results.push_back(r);
    endfunction

    // Advance the decoder by one accepted byte and queue what it yields
    function automatic void parse_rx_byte(input logic [7:0] b);
        int            idx;
        int            cnt;
        logic [15:0]   recv;
        t_frame_result r;
        if (frame_pos == 0) begin
            if (!hunt_armed) begin
                if (b == cfsp_pkg::PRE_FIRST) hunt_armed = 1'b1;
            end else if (b == cfsp_pkg::PRE_SECOND) begin
                frame_pos       = 6'(cfsp_pkg::POS_LEN);
                frame_len_total = '0;
                crc_acc         = cfsp_pkg::CRC_INIT;
            end else if (b != cfsp_pkg::PRE_FIRST) begin
                hunt_armed = 1'b0;
            end
            push_single(cfsp_pkg::STATUS_NEED_MORE);
            return;
        end
        idx       = int'(frame_pos);
        frame_pos = frame_pos + 6'd1;
        if (idx == cfsp_pkg::POS_LEN) begin
            len_q = b;
            if (b < cfsp_pkg::LEN_OVERHEAD ||
                b > cfsp_pkg::LEN_OVERHEAD + cfsp_pkg::MAX_PAYLOAD_DEF) begin
                hunt_reset();
                push_single(cfsp_pkg::STATUS_LEN_ERR);
                return;
            end
            crc_acc         = crc16_byte(cfsp_pkg::CRC_INIT, b);
            frame_len_total = 6'(cfsp_pkg::HDR_BYTES + int'(b));
        end else if (idx == cfsp_pkg::POS_CMD) begin
            cmd_q   = b;
            crc_acc = crc16_byte(crc_acc, b);
        end else if (idx == cfsp_pkg::POS_ADDR) begin
            addr_q  = b;
            crc_acc = crc16_byte(crc_acc, b);
        end else if (idx == int'(frame_len_total) - 2) begin
            crc_lo_q = b;
        end else if (idx == int'(frame_len_total) - 1) begin
            recv = {b, crc_lo_q};
            if (recv != crc_acc) begin
                hunt_reset();
                push_single(cfsp_pkg::STATUS_CRC_ERR);
                return;
            end
            hunt_reset();
            cnt = int'(len_q) - cfsp_pkg::LEN_OVERHEAD;
            if (cnt > cfsp_pkg::MAX_PAYLOAD_DEF) cnt = cfsp_pkg::MAX_PAYLOAD_DEF;
            r        = '0;
            r.status = cfsp_pkg::STATUS_FRAME_OK;
            r.cmd    = cmd_q;
            r.addr   = addr_q;
            r.count  = 6'(cnt);
            r.last   = (cnt == 0);
            want_results.push_back(r);
            for (int i = 0; i < cnt; i++) begin
                r.is_pay = 1'b1;
                r.pbyte  = pay_mem[i];
                r.last   = (i + 1 == cnt);
                want_results.push_back(r);
            end
            return;
        end else begin
            if (idx >= cfsp_pkg::POS_PAYLOAD &&
                idx - cfsp_pkg::POS_PAYLOAD < cfsp_pkg::MAX_PAYLOAD_DEF) begin
                pay_mem[idx - cfsp_pkg::POS_PAYLOAD] = b;
            end
            crc_acc = crc16_byte(crc_acc, b);
        end
        push_single(cfsp_pkg::STATUS_NEED_MORE);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        t_rx_req q;
        q.data  = b;
        q.drain = pend_drain;
        q.hold  = pend_hold;
        rx_pending.push_back(q);
        pend_drain = 0;
        pend_hold  = 0;
        bytes_queued++;
    endtask

    // Queue a full frame: preamble, LEN, CMD, ADDR, payload, CRC low then high
    task automatic add_frame(input int n_pay, input bit bad_crc,
                             input logic [7:0] cmd, input logic [7:0] addr);
        logic [7:0]  body[$];
        logic [15:0] c;
        body.push_back(8'(cfsp_pkg::LEN_OVERHEAD + n_pay));
        body.push_back(cmd);
        body.push_back(addr);
        for (int i = 0; i < n_pay; i++) body.push_back(8'($urandom_range(0, 255)));
        c = cfsp_pkg::CRC_INIT;
        foreach (body[i]) c = crc16_byte(c, body[i]);
        if (bad_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
        add_byte(cfsp_pkg::PRE_FIRST);
        add_byte(cfsp_pkg::PRE_SECOND);
        foreach (body[i]) add_byte(body[i]);
        add_byte(c[7:0]);
        add_byte(c[15:8]);
    endtask

    // Check delivered results, then predict from the byte accepted at this edge
    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result w;
        bit            moved;
        moved = 0;
        if (i_rst_n && o_valid && !i_stall) begin
            moved      = 1;
            got.status = cfsp_pkg::t_status'(o_status);
            got.cmd    = o_cmd_code;
            got.addr   = o_dest_addr;
            got.count  = o_payload_count;
            got.is_pay = o_is_payload;
            got.pbyte  = o_payload_byte;
            got.last   = o_last;
            if (want_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result status %0d", got.status));
            end else begin
                w = want_results.pop_front();
                if (got.status !== w.status)
                    note_mismatch($sformatf("status got %0d want %0d", got.status, w.status));
                if (got.cmd !== w.cmd)
                    note_mismatch($sformatf("cmd_code got %h want %h", got.cmd, w.cmd));
                if (got.addr !== w.addr)
                    note_mismatch($sformatf("dest_addr got %h want %h", got.addr, w.addr));
                if (got.count !== w.count)
                    note_mismatch($sformatf("payload_count got %0d want %0d",
                                            got.count, w.count));
                if (got.is_pay !== w.is_pay)
                    note_mismatch($sformatf("is_payload got %b want %b", got.is_pay, w.is_pay));
                if (got.pbyte !== w.pbyte)
                    note_mismatch($sformatf("payload_byte got %h want %h", got.pbyte, w.pbyte));
                if (got.last !== w.last)
                    note_mismatch($sformatf("last got %b want %b", got.last, w.last));
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            moved = 1;
            parse_rx_byte(i_rx_byte);
            bytes_taken++;
            in_acc <= 1'b1;
        end else begin
            in_acc <= 1'b0;
        end
        if (!i_rst_n || moved) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Sender: hold the current request until taken, then insert gaps or offer the next
    always @(negedge i_clk) begin
        t_rx_req nx;
        logic    v_n;
        if (i_rst_n) begin
            v_n = i_valid && !in_acc;
            if (!v_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (in_acc && !calm && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 10) - 1;
                end else if (rx_pending.size() != 0 &&
                             !(rx_pending[0].drain && want_results.size() != 0)) begin
                    nx  = rx_pending.pop_front();
                    v_n = 1'b1;
                    i_rx_byte <= nx.data;
                    if (nx.hold) hold_asks <= hold_asks + 1;
                end
            end
            i_valid <= v_n;
            calm    <= (rx_pending.size() < CALM_TAIL);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    always @(negedge i_clk) begin
        logic s_n;
        s_n = 1'b0;
        if (i_rst_n) begin
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                s_n = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                s_n = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                s_n = 1'b1;
            end
        end
        i_stall <= s_n;
    end

    initial begin
        int kind;
        int n_pay;
        int k;

        // Directed: repeated first sync then an empty good frame
        add_byte(cfsp_pkg::PRE_FIRST);
        add_frame(0, 0, 8'h00, 8'hFF);
        // Hunt falls back on a stray byte; lone second sync does nothing
        add_byte(cfsp_pkg::PRE_FIRST);
        add_byte(8'h12);
        add_byte(cfsp_pkg::PRE_SECOND);
        // Length just below and just above the legal range
        add_byte(cfsp_pkg::PRE_FIRST);
        add_byte(cfsp_pkg::PRE_SECOND);
        add_byte(8'(cfsp_pkg::LEN_OVERHEAD - 1));
        add_byte(cfsp_pkg::PRE_FIRST);
        add_byte(cfsp_pkg::PRE_SECOND);
        add_byte(8'(cfsp_pkg::LEN_OVERHEAD + cfsp_pkg::MAX_PAYLOAD_DEF + 1));
        // Empty frame with a corrupted CRC
        add_frame(0, 1, 8'hFF, 8'h00);

        // Random: mostly well-formed frames, some corrupt, truncated or noise
        k = 0;
        while (bytes_queued < STIM_TARGET) begin
            if (k == 2) pend_hold = 1;
            if (k == 5) pend_drain = 1;
            kind  = (k == 0) ? 0 : $urandom_range(0, 9);
            n_pay = ($urandom_range(0, 9) == 0) ?
                    $urandom_range(7, cfsp_pkg::MAX_PAYLOAD_DEF) : $urandom_range(0, 6);
            if (k == 0) n_pay = cfsp_pkg::MAX_PAYLOAD_DEF;
            case (kind)
                0, 1, 2, 3, 4, 5: begin
                    add_frame(n_pay, 0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                6: begin
                    add_frame(n_pay, 1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                7: begin
                    add_byte(cfsp_pkg::PRE_FIRST);
                    add_byte(cfsp_pkg::PRE_SECOND);
                    if ($urandom_range(0, 1) == 0) begin
                        add_byte(8'($urandom_range(0, cfsp_pkg::LEN_OVERHEAD - 1)));
                    end else begin
                        add_byte(8'($urandom_range(cfsp_pkg::LEN_OVERHEAD +
                                                   cfsp_pkg::MAX_PAYLOAD_DEF + 1, 255)));
                    end
                end
                8: begin
                    repeat ($urandom_range(1, 4)) begin
                        add_byte(($urandom_range(0, 2) == 0) ? cfsp_pkg::PRE_FIRST
                                                             : 8'($urandom_range(0, 255)));
                    end
                end
                default: begin
                    // Cut a frame short within or just after its header
                    add_byte(cfsp_pkg::PRE_FIRST);
                    add_byte(cfsp_pkg::PRE_SECOND);
                    add_byte(8'($urandom_range(cfsp_pkg::LEN_OVERHEAD,
                                               cfsp_pkg::LEN_OVERHEAD + 6)));
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
                end
            endcase
            k++;
        end

        // Release reset
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to be taken and every result to arrive
        while (bytes_taken < bytes_queued) @(posedge i_clk);
        while (want_results.size() != 0) @(posedge i_clk);
        repeat (cfsp_pkg::MAX_PAYLOAD_DEF + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
